### hw/rtl/icd_pkg.sv
// Shared types and constants for the icon declutter occupancy grid.
`default_nettype none

package icd_pkg;

    // Bitmap storage
    localparam int GRID_WORDS = 1024;
    localparam int WORD_AW    = $clog2(GRID_WORDS);
    localparam int GW_W       = 11;

    // Field widths
    localparam int COORD_W    = 12;
    localparam int SIDE_W     = 8;
    localparam int CELL_W     = 2 * COORD_W + 1;
    localparam int CELL_OUT_W = 15;
    localparam int BIT_W      = 5;
    localparam int STEP_W     = $clog2(COORD_W);

    // Front queue
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 12;

    localparam logic [CFG_AW-1:0] REG_CELL_SIZE     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_VIEW_WIDTH    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_VIEW_HEIGHT   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CELLS_PER_ROW = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GRID_WORDS    = 3'd4;

    localparam logic [SIDE_W-1:0]  RST_CELL_SIZE     = 8'd16;
    localparam logic [COORD_W-1:0] RST_VIEW_WIDTH    = 12'd256;
    localparam logic [COORD_W-1:0] RST_VIEW_HEIGHT   = 12'd256;
    localparam logic [COORD_W-1:0] RST_CELLS_PER_ROW = 12'd16;
    localparam logic [GW_W-1:0]    RST_GRID_WORDS    = 11'd8;

    // Result status codes
    localparam logic [2:0] ST_DRAWN   = 3'd0;
    localparam logic [2:0] ST_REJECT  = 3'd1;
    localparam logic [2:0] ST_BEYOND  = 3'd2;
    localparam logic [2:0] ST_TAKEN   = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // Request class decided by the front
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_ICON   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] ux;
        logic [COORD_W-1:0] uy;
    } q_entry_t;

    // Queue head as seen by the back
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } front_out_t;

    // Back to front control
    typedef struct packed {
        logic pop;
        logic busy;
    } back_ctl_t;

    typedef struct packed {
        logic [SIDE_W-1:0]  cell_size;
        logic [COORD_W-1:0] view_width;
        logic [COORD_W-1:0] view_height;
        logic [COORD_W-1:0] cells_per_row;
        logic [GW_W-1:0]    grid_words;
    } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/icd_front.sv
// Front: classifies incoming requests and holds them in a short queue.
`default_nettype none

module icd_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     action,
    input  wire logic signed [15:0]       pos_x,
    input  wire logic signed [15:0]       pos_y,
    input  wire logic                     has_picture,
    input  wire icd_pkg::cfg_t            cfg,
    input  wire icd_pkg::back_ctl_t       ctl,
    output icd_pkg::front_out_t           head
);
    import icd_pkg::*;

    q_entry_t          fifo_mem [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QCW-1:0]    count_reg;
    logic [QCW-1:0]    count_next;
    logic              push;
    logic              x_out;
    logic              y_out;
    logic              reject;
    q_entry_t          entry;

    // Classification
    always_comb
    begin
        x_out  = pos_x[15] || (pos_x[14:0] >= {3'b000, cfg.view_width});
        y_out  = pos_y[15] || (pos_y[14:0] >= {3'b000, cfg.view_height});
        reject = x_out || y_out || !has_picture;
        entry.ux = pos_x[COORD_W-1:0];
        entry.uy = pos_y[COORD_W-1:0];
        if (!action)
        begin
            entry.kind = KIND_CLEAR;
        end
        else if (reject)
        begin
            entry.kind = KIND_REJECT;
        end
        else
        begin
            entry.kind = KIND_ICON;
        end
    end

    assign in_ready   = (count_reg != QCW'(QDEPTH)) && !ctl.busy;
    assign push       = in_valid && in_ready;
    assign head.valid = (count_reg != '0);
    assign head.entry = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= entry;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(QDEPTH))
        else $error("front queue over depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !ctl.pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("front queue count lost a push");
`endif

endmodule

`default_nettype wire

### hw/rtl/icd_back.sv
// Back: cell computation, bitmap lookup and update, clear sweep, result register.
`default_nettype none

module icd_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire icd_pkg::cfg_t            cfg,
    input  wire icd_pkg::front_out_t      head,
    output icd_pkg::back_ctl_t            ctl,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          draw,
    output logic [2:0]                    status,
    output logic [14:0]                   cell_index
);
    import icd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_ADDR  = 8'b0001_0000,
        S_CHECK = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } back_state_t;

    back_state_t             state_reg;
    back_state_t             state_next;
    logic                    init_reg;
    logic [WORD_AW-1:0]      clr_idx_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [SIDE_W-1:0]       side_reg;
    logic [COORD_W-1:0]      qx_reg;
    logic [COORD_W-1:0]      qy_reg;
    logic [SIDE_W-1:0]       rem_x_reg;
    logic [SIDE_W-1:0]       rem_y_reg;
    logic [2*COORD_W-1:0]    prod_reg;
    logic [CELL_W-1:0]       cell_reg;
    logic [31:0]             rd_data_reg;
    logic                    res_draw_reg;
    logic [2:0]              res_status_reg;
    logic [CELL_OUT_W-1:0]   res_cell_reg;
    logic                    out_valid_reg;
    logic                    draw_reg;
    logic [2:0]              status_reg;
    logic [CELL_OUT_W-1:0]   cell_out_reg;
    logic [31:0]             occ_mem [GRID_WORDS];

    logic [SIDE_W+COORD_W-1:0] step_x;
    logic [SIDE_W+COORD_W-1:0] step_y;
    logic [GW_W-1:0]           limit;
    logic [CELL_W-6:0]         word_full;
    logic                      beyond;
    logic [WORD_AW-1:0]        word_idx;
    logic [31:0]               bit_mask;
    logic                      hit;
    logic                      mem_we;
    logic [WORD_AW-1:0]        mem_addr;
    logic [31:0]               mem_wdata;
    logic                      out_free;

    // One restoring division step: returns {remainder, quotient}
    function automatic logic [SIDE_W+COORD_W-1:0] div_step(
        input logic [SIDE_W-1:0]  rem,
        input logic [COORD_W-1:0] quo,
        input logic [SIDE_W-1:0]  side
    );
        logic [SIDE_W:0]   sh;
        logic              ge;
        logic [SIDE_W:0]   diff;
        logic [SIDE_W-1:0] rem_n;
        sh    = {rem, quo[COORD_W-1]};
        ge    = (sh >= {1'b0, side});
        diff  = sh - {1'b0, side};
        rem_n = ge ? diff[SIDE_W-1:0] : sh[SIDE_W-1:0];
        return {rem_n, quo[COORD_W-2:0], ge};
    endfunction

    assign step_x = div_step(rem_x_reg, qx_reg, side_reg);
    assign step_y = div_step(rem_y_reg, qy_reg, side_reg);

    // Word range check and bit select
    assign limit     = (cfg.grid_words > GW_W'(GRID_WORDS)) ? GW_W'(GRID_WORDS) : cfg.grid_words;
    assign word_full = cell_reg[CELL_W-1:BIT_W];
    assign beyond    = (word_full >= (CELL_W-BIT_W)'(limit));
    assign word_idx  = cell_reg[BIT_W+WORD_AW-1:BIT_W];
    assign bit_mask  = 32'd1 << cell_reg[BIT_W-1:0];
    assign hit       = |(rd_data_reg & bit_mask);

    // Memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = word_idx;
        mem_wdata = rd_data_reg | bit_mask;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_READ && !hit)
        begin
            mem_we = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign ctl.pop  = (state_reg == S_IDLE) && head.valid;
    assign ctl.busy = init_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.entry.kind)
                        KIND_CLEAR:  state_next = S_CLEAR;
                        KIND_ICON:   state_next = S_DIV;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (clr_idx_reg == WORD_AW'(GRID_WORDS - 1))
                begin
                    state_next = init_reg ? S_IDLE : S_RESP;
                end
            end
            S_DIV:
            begin
                if (step_reg == STEP_W'(COORD_W - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_ADDR;
            S_ADDR:  state_next = S_CHECK;
            S_CHECK: state_next = beyond ? S_RESP : S_READ;
            S_READ:  state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_reg      <= 1'b1;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == WORD_AW'(GRID_WORDS - 1))
                begin
                    init_reg <= 1'b0;
                end
            end
            if (state_reg == S_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                qx_reg       <= head.entry.ux;
                qy_reg       <= head.entry.uy;
                rem_x_reg    <= '0;
                rem_y_reg    <= '0;
                step_reg     <= '0;
                side_reg     <= (cfg.cell_size == '0) ? SIDE_W'(1) : cfg.cell_size;
                res_draw_reg <= 1'b0;
                res_cell_reg <= '0;
                res_status_reg <= (head.entry.kind == KIND_CLEAR) ? ST_CLEARED : ST_REJECT;
            end
            S_DIV:
            begin
                {rem_x_reg, qx_reg} <= step_x;
                {rem_y_reg, qy_reg} <= step_y;
                step_reg <= step_reg + 1'b1;
            end
            S_MUL:
            begin
                prod_reg <= (2*COORD_W)'(qy_reg) * (2*COORD_W)'(cfg.cells_per_row);
            end
            S_ADDR:
            begin
                cell_reg <= {1'b0, prod_reg} + CELL_W'(qx_reg);
            end
            S_CHECK:
            begin
                res_cell_reg   <= cell_reg[CELL_OUT_W-1:0];
                res_status_reg <= ST_BEYOND;
            end
            S_READ:
            begin
                res_draw_reg   <= !hit;
                res_status_reg <= hit ? ST_TAKEN : ST_DRAWN;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    draw_reg     <= res_draw_reg;
                    status_reg   <= res_status_reg;
                    cell_out_reg <= res_cell_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Occupancy bitmap
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            occ_mem[mem_addr] <= mem_wdata;
        end
        if (state_reg == S_CHECK)
        begin
            rd_data_reg <= occ_mem[word_idx];
        end
    end

    assign out_valid  = out_valid_reg;
    assign draw       = draw_reg;
    assign status     = status_reg;
    assign cell_index = cell_out_reg;

`ifndef ASSERT_OFF
    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> head.valid)
        else $error("pop from empty queue");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_READ) |-> !beyond)
        else $error("bitmap write beyond words in use");

    a_draw_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && draw_reg) |-> (status_reg == ST_DRAWN))
        else $error("draw without drawn status");
`endif

endmodule

`default_nettype wire

### hw/rtl/icon_declutter_occupancy_grid.sv
// Top level: configuration registers, front classifier and back grid engine.
// Icon request: the bit-serial divider, then multiply, address, check and bitmap read before
// the result (the read is skipped beyond the grid). Rejected request: straight to the result.
// Frame start: one bitmap word cleared per cycle. One request is worked on at a time;
// a two-entry queue takes requests meanwhile. After reset a clearing pass over the bitmap
// holds in_ready low; configuration writes are taken throughout.
`default_nettype none

module icon_declutter_occupancy_grid (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          action,
    input  wire logic signed [15:0]            pos_x,
    input  wire logic signed [15:0]            pos_y,
    input  wire logic                          has_picture,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               draw,
    output logic [2:0]                         status,
    output logic [14:0]                        cell_index,
    input  wire logic                          cfg_we,
    input  wire logic [icd_pkg::CFG_AW-1:0]    cfg_index,
    input  wire logic [icd_pkg::CFG_DW-1:0]    cfg_wdata
);
    import icd_pkg::*;

    cfg_t       cfg_reg;
    back_ctl_t  ctl;
    front_out_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_size     <= RST_CELL_SIZE;
            cfg_reg.view_width    <= RST_VIEW_WIDTH;
            cfg_reg.view_height   <= RST_VIEW_HEIGHT;
            cfg_reg.cells_per_row <= RST_CELLS_PER_ROW;
            cfg_reg.grid_words    <= RST_GRID_WORDS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_SIZE:     cfg_reg.cell_size     <= cfg_wdata[SIDE_W-1:0];
                REG_VIEW_WIDTH:    cfg_reg.view_width    <= cfg_wdata[COORD_W-1:0];
                REG_VIEW_HEIGHT:   cfg_reg.view_height   <= cfg_wdata[COORD_W-1:0];
                REG_CELLS_PER_ROW: cfg_reg.cells_per_row <= cfg_wdata[COORD_W-1:0];
                REG_GRID_WORDS:    cfg_reg.grid_words    <= cfg_wdata[GW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    icd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .has_picture (has_picture),
        .cfg         (cfg_reg),
        .ctl         (ctl),
        .head        (head)
    );

    icd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .draw       (draw),
        .status     (status),
        .cell_index (cell_index)
    );

endmodule

`default_nettype wire

### sim/icon_declutter_occupancy_grid_tb.sv
// Testbench for icon_declutter_occupancy_grid: directed table, random frames, scoreboard.
`default_nettype none

module icon_declutter_occupancy_grid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icd_pkg::*;

    localparam logic ACT_FRAME   = 1'b0;
    localparam logic ACT_ICON    = 1'b1;
    localparam int   STALL_LIMIT = 10000;
    localparam int   PHASES      = 10;
    localparam int   PHASE_ITEMS = 183;
    localparam int   TAIL_CYCLES = 40;

    typedef struct packed {
        logic        draw;
        logic [2:0]  status;
        logic [14:0] cell_no;
    } verdict_t;

    typedef enum logic {
        ROW_REQ,
        ROW_SETTING
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        cfg_t               setting;
        logic               act;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               pic;
        logic               typed;
        verdict_t           want;
    } drill_row_t;

    // Clock and block ports
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic                     action      = 1'b0;
    logic signed [15:0]       pos_x       = '0;
    logic signed [15:0]       pos_y       = '0;
    logic                     has_picture = 1'b0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic                     draw;
    logic [2:0]               status;
    logic [14:0]              cell_index;
    logic                     cfg_we      = 1'b0;
    logic [CFG_AW-1:0]        cfg_index   = '0;
    logic [CFG_DW-1:0]        cfg_wdata   = '0;

    // Predictor state: register copy and occupancy bitmap
    cfg_t        shadow;
    logic [31:0] occupancy [GRID_WORDS];
    verdict_t    pending_verdicts [$];
    drill_row_t  drill [$];
    int          errors       = 0;
    int          quiet_cycles = 0;
    int          stall_left   = 0;
    bit          calm         = 1'b0;

    icon_declutter_occupancy_grid uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .has_picture (has_picture),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .draw        (draw),
        .status      (status),
        .cell_index  (cell_index),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap length: mostly none or short, a few long; none in calm phases
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Expected verdict for one request; updates the bitmap copy
    function automatic verdict_t decide_icon(logic act, logic signed [15:0] px,
                                             logic signed [15:0] py, logic pic);
        verdict_t    v;
        int          xi;
        int          yi;
        int unsigned side;
        int unsigned ux;
        int unsigned uy;
        int unsigned cnum;
        int unsigned word;
        int unsigned lim;
        v  = '{draw: 1'b0, status: ST_REJECT, cell_no: '0};
        xi = int'(px);
        yi = int'(py);
        if (act == ACT_FRAME)
        begin
            foreach (occupancy[i])
                occupancy[i] = '0;
            v.status = ST_CLEARED;
            return v;
        end
        if (xi < 0 || yi < 0 || xi >= int'(shadow.view_width) ||
            yi >= int'(shadow.view_height) || !pic)
            return v;
        // zero cell size acts as one pixel
        side = (shadow.cell_size == '0) ? 1 : int'(shadow.cell_size);
        ux   = xi;
        uy   = yi;
        cnum = ux / side + (uy / side) * int'(shadow.cells_per_row);
        v.cell_no = cnum[14:0];
        word = cnum >> 5;
        lim  = (shadow.grid_words > GRID_WORDS) ? GRID_WORDS : int'(shadow.grid_words);
        if (word >= lim)
        begin
            v.status = ST_BEYOND;
            return v;
        end
        if (occupancy[word][cnum[4:0]])
        begin
            v.status = ST_TAKEN;
            return v;
        end
        occupancy[word][cnum[4:0]] = 1'b1;
        v.draw   = 1'b1;
        v.status = ST_DRAWN;
        return v;
    endfunction

    function automatic cfg_t mk_setting(int cs, int vw, int vh, int cpr, int gw);
        cfg_t s;
        s.cell_size     = cs[SIDE_W-1:0];
        s.view_width    = vw[COORD_W-1:0];
        s.view_height   = vh[COORD_W-1:0];
        s.cells_per_row = cpr[COORD_W-1:0];
        s.grid_words    = gw[GW_W-1:0];
        return s;
    endfunction

    // Mostly consistent grid geometry, sometimes an odd word count
    function automatic cfg_t random_setting();
        int cs;
        int vw;
        int vh;
        int cpr;
        int gw;
        cs  = $urandom_range(1, 64);
        vw  = $urandom_range(16, 1024);
        vh  = $urandom_range(16, 1024);
        cpr = vw / cs;
        gw  = (cpr * (vh / cs)) / 32;
        case ($urandom_range(0, 3))
            0: gw = gw + 1;
            1: gw = $urandom_range(0, 2047);
            default: ;
        endcase
        if (gw > 2047)
            gw = 2047;
        return mk_setting(cs, vw, vh, cpr, gw);
    endfunction

    function automatic void add_req(logic act, int x, int y, logic pic,
                                    logic typed = 1'b0, logic d = 1'b0,
                                    logic [2:0] st = ST_REJECT, int cno = 0);
        drill_row_t r;
        r.kind    = ROW_REQ;
        r.setting = '0;
        r.act     = act;
        r.x       = x[15:0];
        r.y       = y[15:0];
        r.pic     = pic;
        r.typed   = typed;
        r.want    = '{draw: d, status: st, cell_no: cno[14:0]};
        drill     = {drill, r};
    endfunction

    function automatic void add_setting(cfg_t s);
        drill_row_t r;
        r.kind    = ROW_SETTING;
        r.setting = s;
        r.act     = ACT_ICON;
        r.x       = '0;
        r.y       = '0;
        r.pic     = 1'b0;
        r.typed   = 1'b0;
        r.want    = '0;
        drill     = {drill, r};
    endfunction

    // Directed rows; expectations typed only where obvious
    function automatic void build_drill();
        // reset geometry: 16 px cells, 256x256 view, 16 columns, 8 words
        add_req(ACT_FRAME, -32768, 32767, 1'b1, 1'b1, 1'b0, ST_CLEARED, 0);
        add_req(ACT_ICON, 0, 0, 1'b1, 1'b1, 1'b1, ST_DRAWN, 0);
        add_req(ACT_ICON, 0, 0, 1'b1, 1'b1, 1'b0, ST_TAKEN, 0);
        add_req(ACT_ICON, -1, 0, 1'b1, 1'b1);
        add_req(ACT_ICON, 0, -32768, 1'b1, 1'b1);
        add_req(ACT_ICON, 255, 255, 1'b1, 1'b1, 1'b1, ST_DRAWN, 255);
        add_req(ACT_ICON, 256, 0, 1'b1, 1'b1);
        add_req(ACT_ICON, 0, 256, 1'b1, 1'b1);
        add_req(ACT_ICON, 32767, 32767, 1'b1, 1'b1);
        add_req(ACT_ICON, 100, 100, 1'b0, 1'b1);
        add_req(ACT_ICON, -32768, -1, 1'b0, 1'b1);
        add_req(ACT_ICON, 17, 33, 1'b1);
        add_req(ACT_ICON, 15, 15, 1'b1);
        add_req(ACT_FRAME, -1, -1, 1'b0, 1'b1, 1'b0, ST_CLEARED, 0);
        add_req(ACT_ICON, 255, 255, 1'b1, 1'b1, 1'b1, ST_DRAWN, 255);
        // no words in use: everything lands beyond the grid
        add_setting(mk_setting(16, 256, 256, 16, 0));
        add_req(ACT_ICON, 0, 0, 1'b1, 1'b1, 1'b0, ST_BEYOND, 0);
        // zero cell size, full view, word count past storage
        add_setting(mk_setting(0, 4095, 4095, 4095, 2047));
        add_req(ACT_ICON, 4094, 4094, 1'b1);
        add_req(ACT_ICON, 31, 0, 1'b1);
        add_req(ACT_ICON, 4095, 0, 1'b1, 1'b1);
        // empty view
        add_setting(mk_setting(255, 0, 0, 0, 1024));
        add_req(ACT_ICON, 0, 0, 1'b1, 1'b1);
        // widest cell number, low 15 bits wrap to zero
        add_setting(mk_setting(255, 4095, 4095, 4095, 1));
        add_req(ACT_ICON, 4094, 4094, 1'b1);
        add_req(ACT_ICON, 254, 254, 1'b1);
        add_req(ACT_ICON, 255, 0, 1'b1);
        add_req(ACT_FRAME, 32767, -32768, 1'b0);
    endfunction

    // Present one request, hold it until accepted, then record its verdict
    task automatic send_request(logic act, logic signed [15:0] px,
                                logic signed [15:0] py, logic pic,
                                logic typed, verdict_t want);
        int       gap;
        verdict_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        pos_x       <= px;
        pos_y       <= py;
        has_picture <= pic;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = decide_icon(act, px, py, pic);
        pending_verdicts = {pending_verdicts, (typed ? want : predicted)};
    endtask

    // Random request: mostly icons inside the view, some frame starts and noise
    task automatic send_random_item();
        int                 r;
        int                 side;
        int                 box_w;
        int                 box_h;
        logic               act;
        logic               pic;
        logic signed [15:0] px;
        logic signed [15:0] py;
        r   = $urandom_range(0, 99);
        act = ACT_ICON;
        pic = 1'b1;
        px  = 16'($urandom());
        py  = 16'($urandom());
        if (r < 3)
        begin
            act = ACT_FRAME;
            pic = 1'($urandom_range(0, 1));
        end
        else if (r < 83)
        begin
            side  = (shadow.cell_size == '0) ? 1 : int'(shadow.cell_size);
            box_w = int'(shadow.view_width);
            box_h = int'(shadow.view_height);
            // half of them crowd a small corner so cells get reused
            if ($urandom_range(0, 1))
            begin
                if (box_w > side * 8)
                    box_w = side * 8;
                if (box_h > side * 4)
                    box_h = side * 4;
            end
            px = (box_w > 0) ? 16'($urandom_range(0, box_w - 1)) : '0;
            py = (box_h > 0) ? 16'($urandom_range(0, box_h - 1)) : '0;
        end
        else
        begin
            pic = 1'($urandom_range(0, 1));
        end
        send_request(act, px, py, pic, 1'b0, '0);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_verdicts.size() > 0)
            @(posedge clk);
    endtask

    // Write all five registers back to back
    task automatic apply_setting(cfg_t s);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CELL_SIZE;
        cfg_wdata <= {4'b0, s.cell_size};
        @(posedge clk);
        cfg_index <= REG_VIEW_WIDTH;
        cfg_wdata <= s.view_width;
        @(posedge clk);
        cfg_index <= REG_VIEW_HEIGHT;
        cfg_wdata <= s.view_height;
        @(posedge clk);
        cfg_index <= REG_CELLS_PER_ROW;
        cfg_wdata <= s.cells_per_row;
        @(posedge clk);
        cfg_index <= REG_GRID_WORDS;
        cfg_wdata <= {1'b0, s.grid_words};
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow = s;
    endtask

    // Result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Compare each accepted result against the oldest expected verdict
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: result with nothing expected: draw %0b status %0d cell %0d",
                         $time, draw, status, cell_index);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (draw !== want.draw)
                begin
                    $display("%0t: draw expected %0b actual %0b", $time, want.draw, draw);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    errors++;
                end
                if (cell_index !== want.cell_no)
                begin
                    $display("%0t: cell_index expected %0d actual %0d",
                             $time, want.cell_no, cell_index);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("icon_declutter_occupancy_grid regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        cfg_t setting;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        shadow = mk_setting(int'(RST_CELL_SIZE), int'(RST_VIEW_WIDTH),
                            int'(RST_VIEW_HEIGHT), int'(RST_CELLS_PER_ROW),
                            int'(RST_GRID_WORDS));
        foreach (occupancy[i])
            occupancy[i] = '0;

        // directed table
        build_drill();
        foreach (drill[i])
        begin
            if (drill[i].kind == ROW_SETTING)
            begin
                drain();
                apply_setting(drill[i].setting);
            end
            else
            begin
                send_request(drill[i].act, drill[i].x, drill[i].y, drill[i].pic,
                             drill[i].typed, drill[i].want);
            end
        end

        // random phases: reset geometry, then extreme geometry, then random settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: setting = mk_setting(int'(RST_CELL_SIZE), int'(RST_VIEW_WIDTH),
                                        int'(RST_VIEW_HEIGHT), int'(RST_CELLS_PER_ROW),
                                        int'(RST_GRID_WORDS));
                1: setting = mk_setting(1, 4095, 4095, 4095, 1024);
                2: setting = mk_setting(255, 4095, 4095, 16, 2047);
                3: setting = mk_setting(0, 64, 64, 64, 128);
                4: setting = mk_setting(64, 256, 192, 4, 0);
                default: setting = random_setting();
            endcase
            drain();
            calm = (phase % 4 == 2);
            apply_setting(setting);
            repeat (PHASE_ITEMS) send_random_item();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("icon_declutter_occupancy_grid regression: pass");
        else
            $display("icon_declutter_occupancy_grid regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
